// File: design/wft_pkg.sv
// ----------------------------------------------------------------------------
// wft_pkg
// shared types, constants and coefficient helpers for the winograd
// f(6x6,3x3) filter transform
// ----------------------------------------------------------------------------
package wft_pkg;

   localparam int WEIGHT_W    = 16;
   localparam int TAPS        = 3;
   localparam int NUM_W       = TAPS * TAPS;
   localparam int TILE_W      = 32;
   localparam int QUEUE_DEPTH = 2;

   // floor(2^35 / 2025), reciprocal for the rounding divide
   localparam logic [24:0] RECIP      = 25'd16967772;
   localparam logic [11:0] DIVISOR    = 12'd2025;
   localparam logic [9:0]  HALF_DIV   = 10'd1012;

   typedef logic [NUM_W-1:0][WEIGHT_W-1:0] filter_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // v times entry (row, k) of the integer matrix h = 180 * g
   function automatic logic signed [31:0] hmul(input logic signed [31:0] v,
                                               input logic [2:0] row,
                                               input logic [1:0] k);
      logic signed [31:0] r;
      case (row)
         3'd0: r = (k == 2'd0) ? v * 32'sd180 : 32'sd0;
         3'd1: r = -(v * 32'sd40);
         3'd2: r = (k == 2'd1) ? v * 32'sd40 : -(v * 32'sd40);
         3'd3: r = v <<< (k + 2'd1);
         3'd4: r = (k == 2'd1) ? -(v <<< 2) : v <<< (k + 2'd1);
         3'd5: r = v <<< (2'd2 - k);
         3'd6: r = (k == 2'd1) ? -(v <<< 1) : v <<< (2'd2 - k);
         3'd7: r = (k == 2'd2) ? v * 32'sd180 : 32'sd0;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

endpackage

// File: design/wft_front.sv
// ----------------------------------------------------------------------------
// wft_front
// accepts filter requests, applies the 180 degree flip when req_tuser is set
// and pushes the filter into the queue
// ----------------------------------------------------------------------------
module wft_front (
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [143:0]              req_tdata,   // w00, w01, w02, w10 .. w22
   input  logic                      req_tuser,   // mode
   input  wft_pkg::queue_status_type q_status,
   output logic                      q_push,
   output wft_pkg::filter_type       q_data
);
   wft_pkg::filter_type raw;

   assign raw        = req_tdata;
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      for (int n = 0; n < wft_pkg::NUM_W; n++) begin
         q_data[n] = req_tuser ? raw[wft_pkg::NUM_W-1-n] : raw[n];
      end
   end
endmodule

// File: design/wft_queue.sv
// ----------------------------------------------------------------------------
// wft_queue
// short filter queue between front and back
// ----------------------------------------------------------------------------
module wft_queue #(
   parameter int DEPTH = wft_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  wft_pkg::filter_type       push_data,
   input  logic                      pop,
   output wft_pkg::filter_type       head,
   output wft_pkg::queue_status_type status
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   wft_pkg::filter_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign head         = mem_ff[rd_ff];
   assign status.full  = (cnt_ff == CW'(DEPTH));
   assign status.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

// File: design/wft_back.sv
// ----------------------------------------------------------------------------
// wft_back
// walks the 64 tile elements of the head filter through a six stage
// transform and rounding pipeline
// ----------------------------------------------------------------------------
module wft_back (
   input  logic                      clock,
   input  logic                      reset,
   input  wft_pkg::filter_type       head,
   input  wft_pkg::queue_status_type q_status,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [39:0]               rsp_tdata,   // tile_value, tile_row, tile_col
   output logic                      rsp_tlast
);
   logic en, issue;
   logic [5:0] idx_ff, idx_in;

   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff;
   logic [5:0] ia_ff, ib_ff, ic_ff, id_ff, ie_ff, if_ff;

   logic signed [23:0] ta_ff [3];
   logic signed [23:0] ta_in [3];
   logic signed [31:0] sb_ff, sb_in;
   logic [30:0] xc_ff, xd_ff, xe_ff;
   logic [34:0] yc_ff, yd_ff;
   logic sc_ff, sd_ff, se_ff;
   logic [48:0] pd_ff;
   logic [24:0] qe_ff;
   logic [34:0] re_ff;
   logic signed [31:0] vf_val_ff;

   logic [30:0] x_in;
   logic [34:0] y_in;
   logic [24:0] q0;
   logic [36:0] q0m;
   logic [34:0] r_in;
   logic [31:0] mag;
   logic [1:0]  corr;

   assign en    = !vf_ff || rsp_tready;
   assign issue = en && !q_status.empty;
   assign q_pop = issue && (&idx_ff);
   assign idx_in = issue ? idx_ff + 1'b1 : idx_ff;

   // stage a: one row of h * g
   always_comb begin
      for (int c = 0; c < wft_pkg::TAPS; c++) begin
         logic signed [31:0] acc;
         acc = '0;
         for (int k = 0; k < wft_pkg::TAPS; k++) begin
            acc = acc + wft_pkg::hmul(32'(signed'(head[k * wft_pkg::TAPS + c])),
                                      idx_ff[5:3], 2'(k));
         end
         ta_in[c] = acc[23:0];
      end
   end

   // stage b: one element of t * h^T
   always_comb begin
      sb_in = '0;
      for (int k = 0; k < wft_pkg::TAPS; k++) begin
         sb_in = sb_in + wft_pkg::hmul(32'(ta_ff[k]), ia_ff[2:0], 2'(k));
      end
   end

   // stage c: magnitude and remainder term, s*2048/2025 = x + (23x+1012)/2025
   assign x_in = sb_ff[31] ? 31'(-sb_ff) : sb_ff[30:0];
   assign y_in = 35'(x_in) * 35'd23 + 35'(wft_pkg::HALF_DIV);

   // stage e: quotient estimate and remainder
   assign q0   = pd_ff[48:24];
   assign q0m  = 37'(q0) * 37'(wft_pkg::DIVISOR);
   assign r_in = 35'(37'(yd_ff) - q0m);

   // stage f: correction and sign
   always_comb begin
      if (re_ff >= 35'(3 * wft_pkg::DIVISOR)) begin
         corr = 2'd3;
      end else if (re_ff >= 35'(2 * wft_pkg::DIVISOR)) begin
         corr = 2'd2;
      end else if (re_ff >= 35'(wft_pkg::DIVISOR)) begin
         corr = 2'd1;
      end else begin
         corr = 2'd0;
      end
      mag = 32'(xe_ff) + 32'(qe_ff) + 32'(corr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
         vc_ff  <= 1'b0;
         vd_ff  <= 1'b0;
         ve_ff  <= 1'b0;
         vf_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (en) begin
            va_ff <= issue;
            vb_ff <= va_ff;
            vc_ff <= vb_ff;
            vd_ff <= vc_ff;
            ve_ff <= vd_ff;
            vf_ff <= ve_ff;
         end
      end
      if (en) begin
         ia_ff <= idx_ff;
         ib_ff <= ia_ff;
         ic_ff <= ib_ff;
         id_ff <= ic_ff;
         ie_ff <= id_ff;
         if_ff <= ie_ff;
         for (int c = 0; c < wft_pkg::TAPS; c++) begin
            ta_ff[c] <= ta_in[c];
         end
         sb_ff <= sb_in;
         xc_ff <= x_in;
         yc_ff <= y_in;
         sc_ff <= sb_ff[31];
         xd_ff <= xc_ff;
         yd_ff <= yc_ff;
         sd_ff <= sc_ff;
         pd_ff <= 49'(yc_ff[34:11]) * 49'(wft_pkg::RECIP);
         xe_ff <= xd_ff;
         se_ff <= sd_ff;
         qe_ff <= q0;
         re_ff <= r_in;
         vf_val_ff <= se_ff ? -signed'(mag) : signed'(mag);
      end
   end

   assign rsp_tvalid = vf_ff;
   assign rsp_tdata  = {2'b00, if_ff[2:0], if_ff[5:3], vf_val_ff};
   assign rsp_tlast  = &if_ff;
endmodule

// File: design/winograd_filter_transform_6x6_3x3_top.sv
// ----------------------------------------------------------------------------
// winograd_filter_transform_6x6_3x3_top
// winograd f(6x6,3x3) filter transform, one 3x3 filter in, 64 tile values out
// throughput: one tile value per cycle while rsp_tready is held, set by the
// back end element counter; the queue holds further filters meanwhile
// reset: synchronous, clears the queue pointers, counter and pipeline valids
// ----------------------------------------------------------------------------
module winograd_filter_transform_6x6_3x3_top #(
   parameter int QUEUE_DEPTH = wft_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // w00, w01, w02, w10, w11, w12, w20, w21, w22
   input  logic         req_tuser,   // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // tile_value, tile_row, tile_col
   output logic         rsp_tlast    // last
);
   wft_pkg::queue_status_type q_status;
   wft_pkg::filter_type       q_in, q_head;
   logic                      q_push, q_pop;

   wft_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   wft_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   wft_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
